// ===== rtl/cmse_pkg.sv =====
// ============================================================================
// cmse_pkg: shared types and constants for the color matrix sRGB encoder
// Holds the fixed field widths, the fixed-point scale of the matrix sums
// and the configuration register indexes.
// ============================================================================
package cmse_pkg;

    // Field widths fixed by the pixel formats.
    localparam int PIX_W   = 16;   // signed Q1.14 camera sample
    localparam int COEF_W  = 16;   // signed Q4.11 matrix coefficient
    localparam int PROD_W  = PIX_W + COEF_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int ROW_W   = 3 * COEF_W;
    localparam int SRGB_W  = 8;
    localparam int NUM_CH  = 3;

    // The matrix sums are Q8.25, so 1.0 sits at bit 25.
    localparam int SUM_FRAC = 25;
    localparam int CLAMP_W  = SUM_FRAC + 1;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW_RED   = 2'd0,
        CFG_ROW_GREEN = 2'd1,
        CFG_ROW_BLUE  = 2'd2
    } cfg_index_t;

    // Reset rows form the identity matrix (1.0 is 2048 in Q4.11).
    localparam logic [ROW_W-1:0] ROW_RED_RST   = 48'h0000_0000_0800;
    localparam logic [ROW_W-1:0] ROW_GREEN_RST = 48'h0000_0800_0000;
    localparam logic [ROW_W-1:0] ROW_BLUE_RST  = 48'h0800_0000_0000;

endpackage

// ===== rtl/cmse_cam_if.sv =====
// ============================================================================
// cmse_cam_if: camera pixel channel
// Valid/ready channel that carries one linear camera RGB pixel per transfer.
// ============================================================================
interface cmse_cam_if;
    import cmse_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [PIX_W-1:0] cam_red;
    logic signed [PIX_W-1:0] cam_green;
    logic signed [PIX_W-1:0] cam_blue;

    modport source (output valid, output cam_red, output cam_green, output cam_blue,
                    input ready);
    modport sink   (input valid, input cam_red, input cam_green, input cam_blue,
                    output ready);
endinterface

// ===== rtl/cmse_srgb_if.sv =====
// ============================================================================
// cmse_srgb_if: sRGB pixel channel
// Valid/ready channel that carries one gamma-encoded pixel (8 bits per channel) per transfer.
// ============================================================================
interface cmse_srgb_if;
    import cmse_pkg::*;

    logic              valid;
    logic              ready;
    logic [SRGB_W-1:0] srgb_red;
    logic [SRGB_W-1:0] srgb_green;
    logic [SRGB_W-1:0] srgb_blue;

    modport source (output valid, output srgb_red, output srgb_green, output srgb_blue,
                    input ready);
    modport sink   (input valid, input srgb_red, input srgb_green, input srgb_blue,
                    output ready);
endinterface

// ===== rtl/color_matrix_srgb_encode.sv =====
// ============================================================================
// color_matrix_srgb_encode: camera RGB to 8-bit sRGB converter
// Applies a 3x3 color correction matrix, clamps each channel to 0..1 and
// encodes it with the sRGB transfer curve through a lookup ROM.
// ============================================================================
// Usage:
// Linear camera pixels (signed Q1.14) arrive on the cam channel and encoded
// sRGB pixels leave on the srgb channel; both are valid/ready channels and a
// transfer happens when valid and ready are high at a rising clock edge.
// The matrix rows are written through cfg_we/cfg_index/cfg_data while the
// block is idle; a write to an index past the blue row is ignored.
// The datapath is a four-stage pipeline: input register, product register
// (nine 16x16 multipliers), ROM address register (sums, clamp, rounding)
// and the output register, which is loaded from the transfer-curve ROM.
// A pixel passes the input, product, ROM address and output registers in
// that order before it is offered on srgb; one pixel is taken per clock
// when the receiver keeps ready high.
// Each stage loads whenever it is empty or its successor loads, so bubbles
// are squeezed out: when the receiver stalls, the pipeline keeps accepting
// pixels until all four stages are full, and then holds every stage.
// Reset empties the pipeline and returns the matrix to identity. The ROM has
// 2^LUT_ADDR_BITS + 1 entries, is computed at elaboration and is read by
// three copies, one for each channel.
// ============================================================================
module color_matrix_srgb_encode #(
    parameter int LUT_ADDR_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    cmse_cam_if.sink                              cam,
    cmse_srgb_if.source                           srgb,
    input  logic                                  cfg_we,
    input  logic [cmse_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [cmse_pkg::ROW_W-1:0]            cfg_data
);
    import cmse_pkg::*;

    // ------------------------------------------------------------------
    // Transfer-curve ROM, built at elaboration with exact integer math.
    // ------------------------------------------------------------------
    localparam int      LUT_ONE   = 1 << LUT_ADDR_BITS;
    localparam int      ROM_DEPTH = LUT_ONE + 1;
    localparam int      ADDR_W    = LUT_ADDR_BITS + 1;
    localparam longint  LinDiv    = 10 * longint'(LUT_ONE);
    localparam longint  LinLimit  = 31308 * longint'(LUT_ONE);
    localparam int      BIG_W     = 280;
    localparam int      ADDR_SHIFT = SUM_FRAC - LUT_ADDR_BITS;
    localparam logic [CLAMP_W:0] ADDR_RND = (CLAMP_W + 1)'(1) << (ADDR_SHIFT - 1);
    localparam logic [CLAMP_W-1:0] CLAMP_ONE = CLAMP_W'(1) << SUM_FRAC;

    typedef logic [SRGB_W-1:0] rom_t [ROM_DEPTH];

    // True when 1.055*(i/2^L)^(5/12) - 0.055 reaches (k+0.5)/255, checked as
    // i^5 * 10761^12 >= (40k+581)^12 * 2^(5L).
    function automatic logic pow_reaches(input int i, input int k);
        logic [BIG_W-1:0] lhs;
        logic [BIG_W-1:0] rhs;
        lhs = BIG_W'(1);
        rhs = BIG_W'(1);
        for (int n = 0; n < 5; n++)
        begin
            lhs = lhs * BIG_W'(i);
        end
        for (int n = 0; n < 12; n++)
        begin
            lhs = lhs * BIG_W'(10761);
            rhs = rhs * BIG_W'(40 * k + 581);
        end
        rhs = rhs << (5 * LUT_ADDR_BITS);
        return lhs >= rhs;
    endfunction

    function automatic rom_t build_rom();
        rom_t   rom;
        int     thr [255];
        int     lo;
        int     hi;
        int     mid;
        int     p;
        longint q;
        longint c;
        for (int k = 0; k < 255; k++)
        begin
            lo = 0;
            hi = LUT_ONE;
            while (lo < hi)
            begin
                mid = (lo + hi) >> 1;
                if (pow_reaches(mid, k))
                    hi = mid;
                else
                    lo = mid + 1;
            end
            thr[k] = lo;
        end
        p = 0;
        for (int i = 0; i <= LUT_ONE; i++)
        begin
            while (p < 255 && thr[p] <= i)
            begin
                p++;
            end
            if (longint'(i) * 10000000 <= LinLimit)
            begin
                // Linear segment: 3294.6 * i / 2^L, rounded half up.
                q = (65892 * longint'(i)) / LinDiv;
                c = (q + 1) >> 1;
                rom[i] = (c > 255) ? SRGB_W'(255) : SRGB_W'(c);
            end
            else
            begin
                rom[i] = SRGB_W'(p);
            end
        end
        return rom;
    endfunction

    localparam rom_t SRGB_ROM = build_rom();

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic [ROW_W-1:0] row_reg [NUM_CH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_RED_RST;
            row_reg[1] <= ROW_GREEN_RST;
            row_reg[2] <= ROW_BLUE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROW_RED:   row_reg[0] <= cfg_data;
                CFG_ROW_GREEN: row_reg[1] <= cfg_data;
                CFG_ROW_BLUE:  row_reg[2] <= cfg_data;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline control: a stage loads when it is empty or its successor
    // loads.
    // ------------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld1, ld2, ld3, ld4;

    assign ld4       = !v4_reg || srgb.ready;
    assign ld3       = !v3_reg || ld4;
    assign ld2       = !v2_reg || ld3;
    assign ld1       = !v1_reg || ld2;
    assign cam.ready = ld1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (ld1) v1_reg <= cam.valid;
            if (ld2) v2_reg <= v1_reg;
            if (ld3) v3_reg <= v2_reg;
            if (ld4) v4_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Datapath.
    // ------------------------------------------------------------------
    logic signed [PIX_W-1:0]  pix_reg  [NUM_CH];
    logic signed [PROD_W-1:0] prod_reg [NUM_CH][NUM_CH];
    logic signed [PROD_W-1:0] prod_next [NUM_CH][NUM_CH];
    logic [ADDR_W-1:0]        addr_reg  [NUM_CH];
    logic [ADDR_W-1:0]        addr_next [NUM_CH];
    logic [SRGB_W-1:0]        srgb_reg  [NUM_CH];

    // Products: channel c, term j uses coefficient j of row c and input j.
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            for (int j = 0; j < NUM_CH; j++)
            begin
                prod_next[c][j] = $signed(row_reg[c][j*COEF_W +: COEF_W]) * pix_reg[j];
            end
        end
    end

    // Sum, clamp to 0..1.0 and round to a ROM address (half up).
    always_comb
    begin
        logic signed [SUM_W-1:0] sum;
        logic [CLAMP_W-1:0]      clamped;
        logic [CLAMP_W:0]        rounded;
        for (int c = 0; c < NUM_CH; c++)
        begin
            sum = SUM_W'(prod_reg[c][0]) + SUM_W'(prod_reg[c][1]) + SUM_W'(prod_reg[c][2]);
            priority if (sum < 0)
                clamped = '0;
            else if (sum > $signed({{(SUM_W-CLAMP_W){1'b0}}, CLAMP_ONE}))
                clamped = CLAMP_ONE;
            else
                clamped = sum[CLAMP_W-1:0];
            rounded      = ({1'b0, clamped} + ADDR_RND) >> ADDR_SHIFT;
            addr_next[c] = rounded[ADDR_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            pix_reg[0] <= cam.cam_red;
            pix_reg[1] <= cam.cam_green;
            pix_reg[2] <= cam.cam_blue;
        end
        if (ld2)
        begin
            prod_reg <= prod_next;
        end
        if (ld3)
        begin
            addr_reg <= addr_next;
        end
        if (ld4)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                srgb_reg[c] <= SRGB_ROM[addr_reg[c]];
            end
        end
    end

    assign srgb.valid      = v4_reg;
    assign srgb.srgb_red   = srgb_reg[0];
    assign srgb.srgb_green = srgb_reg[1];
    assign srgb.srgb_blue  = srgb_reg[2];

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // A full pipeline facing a stalled receiver takes no new pixel.
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (v1_reg && v2_reg && v3_reg && v4_reg && !srgb.ready) |-> !cam.ready)
        else $error("pixel accepted into a full stalled pipeline");

    // An accepted pixel always occupies the input stage next cycle.
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (cam.valid && cam.ready) |=> v1_reg)
        else $error("accepted pixel lost at the input stage");

    // The rounded address never passes the last ROM entry.
    a_addr_range: assert property (@(posedge clk) disable iff (!rst_n)
        v3_reg |-> (addr_reg[0] <= ADDR_W'(LUT_ONE) && addr_reg[1] <= ADDR_W'(LUT_ONE)
                    && addr_reg[2] <= ADDR_W'(LUT_ONE)))
        else $error("ROM address out of range");

    // A delivered result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (srgb.valid && srgb.ready && !v3_reg) |=> !srgb.valid)
        else $error("result repeated after transfer");
`endif

endmodule

// ===== dv/cmse_srgb_checker.sv =====
// ============================================================================
// cmse_srgb_checker: pixel scoreboard for the color matrix sRGB encoder
// Watches the camera and sRGB channels and the matrix write port, predicts
// each encoded pixel from its own copy of the matrix and transfer-curve ROM,
// and compares every sRGB transfer with the oldest predicted pixel.
// ============================================================================
module cmse_srgb_checker #(
    parameter int LUT_ADDR_BITS = 12
) (
    input  logic                           clk,
    input  logic                           rst_n,
    cmse_cam_if                            cam,
    cmse_srgb_if                           srgb,
    input  logic                           cfg_we,
    input  logic [cmse_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [cmse_pkg::ROW_W-1:0]     cfg_data,
    output int                             pending,
    output int                             mismatches
);
    import cmse_pkg::*;

    localparam int     LUT_TOP = 1 << LUT_ADDR_BITS;
    localparam longint SUM_ONE = longint'(1) << SUM_FRAC;

    typedef struct packed {
        logic [SRGB_W-1:0] red;
        logic [SRGB_W-1:0] green;
        logic [SRGB_W-1:0] blue;
    } srgb_pixel_t;

    logic [SRGB_W-1:0] curve_rom [0:LUT_TOP];
    logic [ROW_W-1:0]  row_red;
    logic [ROW_W-1:0]  row_green;
    logic [ROW_W-1:0]  row_blue;
    srgb_pixel_t       expected_q [$];
    int                fault_count;

    assign pending    = expected_q.size();
    assign mismatches = fault_count;

    // True when 1.055*(addr/2^L)^(5/12) - 0.055 reaches (code+0.5)/255,
    // checked exactly as addr^5 * 10761^12 >= (40*code+581)^12 * 2^(5L).
    function automatic bit curve_reaches(int unsigned addr, int unsigned code);
        logic [255:0] lhs;
        logic [255:0] rhs;
        lhs = 256'd1;
        rhs = 256'd1;
        for (int n = 0; n < 5; n++)
        begin
            lhs = lhs * 256'(addr);
            rhs = rhs * 256'(LUT_TOP);
        end
        for (int n = 0; n < 12; n++)
        begin
            lhs = lhs * 256'(10761);
            rhs = rhs * 256'(40 * code + 581);
        end
        return lhs >= rhs;
    endfunction

    // The ROM entry for each address is the number of output codes whose
    // rounding threshold lies at or below it; the linear toe is computed directly.
    initial
    begin
        int unsigned knee [0:254];
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        int unsigned code;
        longint      q;
        longint      c;
        for (int k = 0; k < 255; k++)
        begin
            lo = 0;
            hi = LUT_TOP;
            while (lo < hi)
            begin
                mid = (lo + hi) / 2;
                if (curve_reaches(mid, k))
                    hi = mid;
                else
                    lo = mid + 1;
            end
            knee[k] = lo;
        end
        code = 0;
        for (int i = 0; i <= LUT_TOP; i++)
        begin
            while (code < 255 && knee[code] <= i)
                code++;
            if (longint'(i) * 10000000 <= longint'(31308) * LUT_TOP)
            begin
                q = (longint'(65892) * i) / (10 * LUT_TOP);
                c = (q + 1) / 2;
                curve_rom[i] = (c > 255) ? 8'd255 : c[SRGB_W-1:0];
            end
            else
            begin
                curve_rom[i] = code[SRGB_W-1:0];
            end
        end
    end

    function automatic logic [SRGB_W-1:0] encode_sum(
        input logic [ROW_W-1:0]        row,
        input logic signed [PIX_W-1:0] r,
        input logic signed [PIX_W-1:0] g,
        input logic signed [PIX_W-1:0] b
    );
        longint acc;
        longint addr;
        acc = longint'($signed(row[COEF_W-1:0])) * longint'(r)
            + longint'($signed(row[2*COEF_W-1:COEF_W])) * longint'(g)
            + longint'($signed(row[3*COEF_W-1:2*COEF_W])) * longint'(b);
        if (acc < 0)
            acc = 0;
        else if (acc > SUM_ONE)
            acc = SUM_ONE;
        addr = (acc + (longint'(1) << (SUM_FRAC - 1 - LUT_ADDR_BITS)))
               >> (SUM_FRAC - LUT_ADDR_BITS);
        return curve_rom[addr];
    endfunction

    task automatic note_fault(input bit unexpected, input srgb_pixel_t want,
                              input srgb_pixel_t got);
        fault_count++;
        if (fault_count <= 10)
        begin
            if (unexpected)
                $display("ERROR: sRGB transfer with no pixel pending: r=%0d g=%0d b=%0d",
                         got.red, got.green, got.blue);
            else
                $display({"ERROR: sRGB mismatch: expected r=%0d g=%0d b=%0d, ",
                          "got r=%0d g=%0d b=%0d"},
                         want.red, want.green, want.blue, got.red, got.green, got.blue);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        srgb_pixel_t got;
        srgb_pixel_t want;
        if (!rst_n)
        begin
            row_red     <= ROW_RED_RST;
            row_green   <= ROW_GREEN_RST;
            row_blue    <= ROW_BLUE_RST;
            expected_q.delete();
            fault_count = 0;
        end
        else
        begin
            if (srgb.valid && srgb.ready)
            begin
                got = '{srgb.srgb_red, srgb.srgb_green, srgb.srgb_blue};
                if (expected_q.size() == 0)
                begin
                    note_fault(1'b1, got, got);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green
                        || got.blue !== want.blue)
                        note_fault(1'b0, want, got);
                end
            end
            if (cam.valid && cam.ready)
                expected_q.push_back('{
                    encode_sum(row_red,   cam.cam_red, cam.cam_green, cam.cam_blue),
                    encode_sum(row_green, cam.cam_red, cam.cam_green, cam.cam_blue),
                    encode_sum(row_blue,  cam.cam_red, cam.cam_green, cam.cam_blue)});
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ROW_RED:   row_red   <= cfg_data;
                    CFG_ROW_GREEN: row_green <= cfg_data;
                    CFG_ROW_BLUE:  row_blue  <= cfg_data;
                    default:       ;
                endcase
            end
        end
    end

endmodule

// ===== dv/color_matrix_srgb_encode_tb.sv =====
// ============================================================================
// color_matrix_srgb_encode_tb: testbench for the color matrix sRGB encoder
// Drives camera pixels and matrix writes, applies random back-pressure on the
// sRGB channel, and relies on the checker for the predicted pixels.
// ============================================================================
module color_matrix_srgb_encode_tb;
    import cmse_pkg::*;

    localparam int LUT_ADDR_BITS   = 12;
    // Cycles with no transfer on either channel before the run is abandoned.
    // The longest legal quiet stretch is a few matrix writes or a receiver
    // stall streak, both far below this.
    localparam int QUIET_LIMIT     = 2000;
    localparam int RANDOM_PHASES   = 6;
    localparam int ITEMS_PER_PHASE = 150;
    // Index past the blue row; the block must drop writes to it.
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [ROW_W-1:0]     cfg_data;
    int unsigned          idle_pct;
    int unsigned          stall_pct;
    int                   pending;
    int                   mismatches;
    int                   quiet_cycles;

    cmse_cam_if  cam_ch ();
    cmse_srgb_if srgb_ch ();

    color_matrix_srgb_encode #(
        .LUT_ADDR_BITS(LUT_ADDR_BITS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cam      (cam_ch),
        .srgb     (srgb_ch),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // The checker predicts every pixel and reports how many are still owed
    // and how many transfers were wrong.
    cmse_srgb_checker #(
        .LUT_ADDR_BITS(LUT_ADDR_BITS)
    ) i_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .cam       (cam_ch),
        .srgb      (srgb_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pending   (pending),
        .mismatches(mismatches)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver drops ready at random; stall_pct is set per phase.
    always @(negedge clk)
        srgb_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    // Watchdog: a hung pipeline shows up as a long run of cycles in which
    // neither channel completes a transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cam_ch.valid && cam_ch.ready) || (srgb_ch.valid && srgb_ch.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("color_matrix_srgb_encode_tb failed");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Offers one camera pixel, first idling the sender at random, and returns
    // on the falling edge after the transfer. valid is left high so that a
    // following pixel goes out back to back.
    task automatic send_pixel(input logic signed [PIX_W-1:0] r,
                              input logic signed [PIX_W-1:0] g,
                              input logic signed [PIX_W-1:0] b);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            cam_ch.valid <= 1'b0;
            @(negedge clk);
        end
        cam_ch.valid     <= 1'b1;
        cam_ch.cam_red   <= r;
        cam_ch.cam_green <= g;
        cam_ch.cam_blue  <= b;
        @(posedge clk);
        while (!cam_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Stops sending and waits until every predicted pixel has come out.
    // Every pixel produces a result, so nothing is left in flight after this.
    task automatic drain_pipeline();
        cam_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // One matrix write; the enable is dropped again after each write
    // so that it never gets two assignments in one step.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [ROW_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        @(negedge clk);
    endtask

    task automatic load_matrix(input logic [ROW_W-1:0] red, input logic [ROW_W-1:0] green,
                               input logic [ROW_W-1:0] blue);
        drain_pipeline();
        cfg_write(CFG_ROW_RED, red);
        cfg_write(CFG_ROW_GREEN, green);
        cfg_write(CFG_ROW_BLUE, blue);
    endtask

    // A matrix row in the shape of a real camera correction: a gain of 1.0
    // to 2.0 on the diagonal and small, mostly negative, cross terms. A wild
    // row is all random bits, which mostly drives the sums into the clamps.
    function automatic logic [ROW_W-1:0] color_row(input int diag, input bit wild);
        logic [COEF_W-1:0] coef [3];
        if (wild)
            return ROW_W'({$urandom(), $urandom()});
        for (int c = 0; c < 3; c++)
        begin
            if (c == diag)
                coef[c] = COEF_W'($urandom_range(2048, 4096));
            else
                coef[c] = COEF_W'(int'($urandom_range(0, 1792)) - 1536);
        end
        return {coef[2], coef[1], coef[0]};
    endfunction

    // Camera samples: mostly in 0..1.0, with some from the dark toe where
    // the curve is linear, some highlights above 1.0, some negative noise
    // and some fully random words.
    function automatic logic signed [PIX_W-1:0] camera_sample();
        case ($urandom_range(0, 9))
            6:       return PIX_W'($urandom_range(0, 64));
            7:       return PIX_W'($urandom());
            8:       return PIX_W'($urandom_range(16384, 32767));
            9:       return PIX_W'(-int'($urandom_range(0, 2048)));
            default: return PIX_W'($urandom_range(0, 16384));
        endcase
    endfunction

    initial
    begin
        bit wild;
        // Per-phase idling: none, sender only, receiver only, both.
        int unsigned idle_by_phase  [4];
        int unsigned stall_by_phase [4];

        idle_by_phase    = '{0, 62, 0, 23};
        stall_by_phase   = '{0, 0, 62, 23};
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_ROW_RED;
        cfg_data         = '0;
        cam_ch.valid     = 1'b0;
        cam_ch.cam_red   = '0;
        cam_ch.cam_green = '0;
        cam_ch.cam_blue  = '0;
        idle_pct         = 0;
        stall_pct        = 0;

        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed pixels through the identity matrix left by reset: black,
        // exactly 1.0, the negative and positive extremes (clamped to 0 and
        // 1), the half-up address rounding at the bottom, the edge of the
        // linear toe and alternating bit patterns.
        send_pixel(16'sd0, 16'sd0, 16'sd0);
        send_pixel(16'sd16384, 16'sd16384, 16'sd16384);
        send_pixel(-16'sd32768, -16'sd32768, -16'sd32768);
        send_pixel(16'sd32767, 16'sd32767, 16'sd32767);
        send_pixel(16'sd1, 16'sd2, 16'sd3);
        send_pixel(16'sd48, 16'sd52, 16'sd50);
        send_pixel(16'sh5555, 16'shAAAA, 16'sh7FFF);
        send_pixel(16'sd16384, 16'sd0, -16'sd1);
        send_pixel(16'sd8192, 16'sd4096, 16'sd2048);

        // Extreme coefficients: the largest positive and negative Q4.11
        // values, so the sums reach their full width in both directions.
        load_matrix(48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, 48'h0001_8000_7FFF);
        send_pixel(16'sd32767, 16'sd32767, 16'sd32767);
        send_pixel(-16'sd32768, -16'sd32768, -16'sd32768);
        send_pixel(-16'sd32768, 16'sd32767, 16'sd0);
        send_pixel(16'sd1, -16'sd1, 16'sd1);
        send_pixel(16'sd16, 16'sd0, 16'sd0);

        // A write past the blue row must leave the matrix untouched.
        drain_pipeline();
        cfg_write(CFG_IDX_UNUSED, '1);
        send_pixel(16'sd16384, 16'sd16384, 16'sd16384);

        // The all-zero matrix forces every channel to black.
        load_matrix('0, '0, '0);
        send_pixel(16'sd32767, -16'sd32768, 16'sd16384);

        // Random phases. Each one loads a fresh matrix while the pipeline is
        // empty and then streams pixels under its own idle pattern.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wild = (phase % 3 == 2);
            load_matrix(color_row(0, wild), color_row(1, wild), color_row(2, wild));
            idle_pct  = idle_by_phase[phase % 4];
            stall_pct = stall_by_phase[phase % 4];
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // Once mid-stream, hold the sender off until the pipeline
                // has fully emptied under receiver back-pressure.
                if (phase == 2 && n == ITEMS_PER_PHASE / 2)
                    drain_pipeline();
                send_pixel(camera_sample(), camera_sample(), camera_sample());
            end
        end

        // Let the pipeline empty with ready held high, then give a few more
        // cycles so that any stray transfer is caught.
        stall_pct = 0;
        drain_pipeline();
        repeat (8) @(negedge clk);

        if (mismatches == 0)
            $display("color_matrix_srgb_encode_tb passed");
        else
            $display("color_matrix_srgb_encode_tb failed");
        $finish;
    end

endmodule
